### sv/stclp_pkg.sv
// Shared types, constants and helper functions for the time-setting line parser.
package stclp_pkg;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_COMMA = 8'd44;

  localparam int unsigned NUM_VALUES = 6;

  localparam logic [4:0] PHASE_FIRST_NUM = 5'd8;
  localparam logic [4:0] PHASE_LAST_RUN  = 5'd19;
  localparam logic [4:0] PHASE_DONE      = 5'd20;

  localparam logic [2:0] LAST_VALUE     = 3'd5;
  localparam logic [7:0] YEAR_BASE_MOD  = 8'd208;
  localparam logic [7:0] WEEKDAY_FIXED  = 8'h01;

  typedef struct packed {
    logic       cmd_ok;
    logic [7:0] sec_bcd;
    logic [7:0] min_bcd;
    logic [7:0] hour_bcd;
    logic [7:0] weekday_bcd;
    logic [7:0] date_bcd;
    logic [7:0] month_bcd;
    logic [7:0] year_bcd;
  } res_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h53; // S
      3'd1:    ch = 8'h45; // E
      3'd2:    ch = 8'h54; // T
      3'd3:    ch = 8'h54; // T
      3'd4:    ch = 8'h49; // I
      3'd5:    ch = 8'h4D; // M
      3'd6:    ch = 8'h45; // E
      default: ch = CHAR_COMMA;
    endcase
    return ch;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c == 8'd9) || (c == 8'd11) || (c == 8'd12);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  // Divide by ten through the reciprocal 205/2048, exact for all byte values.
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  tens;
    logic [7:0]  rem;
    prod = 16'(v) * 16'd205;
    tens = prod[15:11];
    rem  = v - 8'({tens, 3'b000} + {2'b00, tens, 1'b0});
    return {tens[3:0], rem[3:0]};
  endfunction

endpackage

### sv/stclp_core.sv
// Line gathering and incremental command parse, one byte per transfer.
module stclp_core #(
  parameter int unsigned LINE_BUFFER_BYTES = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output stclp_pkg::res_t   res
);
  import stclp_pkg::*;

  localparam int unsigned LEN_W = $clog2(LINE_BUFFER_BYTES);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BUFFER_BYTES - 1);

  logic [LEN_W-1:0] line_length, line_length_next;
  logic [4:0]       parse_phase, parse_phase_next;
  logic             parse_failed, parse_failed_next;
  logic             text_ended, text_ended_next;
  logic [7:0]       number_accumulator, number_accumulator_next;
  logic             number_negative, number_negative_next;
  logic             number_has_digit, number_has_digit_next;
  logic [7:0]       parsed_values [NUM_VALUES];

  logic       pv_we;
  logic [2:0] pv_idx;
  logic [7:0] pv_data;

  logic       term;
  logic       digit;
  logic [3:0] dval;
  logic [4:0] phase_rel;
  logic       go_on;
  logic [7:0] acc_src;
  logic       has_src;
  logic [7:0] signed_acc;
  logic       ok;
  logic [7:0] last_value;

  assign term       = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
  assign digit      = is_digit(rx_byte);
  assign dval       = rx_byte[3:0];
  assign phase_rel  = parse_phase - PHASE_FIRST_NUM;
  assign signed_acc = number_negative ? (8'd0 - number_accumulator) : number_accumulator;

  always_comb begin
    line_length_next        = line_length;
    parse_phase_next        = parse_phase;
    parse_failed_next       = parse_failed;
    text_ended_next         = text_ended;
    number_accumulator_next = number_accumulator;
    number_negative_next    = number_negative;
    number_has_digit_next   = number_has_digit;
    pv_we                   = 1'b0;
    pv_idx                  = phase_rel[3:1];
    pv_data                 = signed_acc;
    res_valid               = 1'b0;
    go_on                   = 1'b1;
    acc_src                 = number_accumulator;
    has_src                 = number_has_digit;

    if (accept) begin
      if (!term) begin
        if (line_length < LEN_MAX) begin
          line_length_next = line_length + 1'b1;
          if (!text_ended && !parse_failed) begin
            if (rx_byte == CHAR_NUL) begin
              text_ended_next = 1'b1;
            end else if (parse_phase < PHASE_FIRST_NUM) begin
              if (rx_byte == prefix_char(parse_phase[2:0])) begin
                parse_phase_next = parse_phase + 1'b1;
              end else begin
                parse_failed_next = 1'b1;
              end
            end else if (parse_phase < PHASE_DONE) begin
              // Even phase: start of a decimal, skip blanks and take a sign.
              if (!phase_rel[0]) begin
                if (is_blank(rx_byte)) begin
                  go_on = 1'b0;
                end else if (rx_byte != CHAR_PLUS && rx_byte != CHAR_MINUS && !digit) begin
                  parse_failed_next = 1'b1;
                  go_on = 1'b0;
                end else begin
                  acc_src                 = 8'd0;
                  has_src                 = 1'b0;
                  number_accumulator_next = 8'd0;
                  number_has_digit_next   = 1'b0;
                  number_negative_next    = (rx_byte == CHAR_MINUS);
                  parse_phase_next        = parse_phase + 1'b1;
                  go_on                   = digit;
                end
              end
              if (go_on) begin
                if (digit) begin
                  number_accumulator_next = {acc_src[4:0], 3'b000} + {acc_src[6:0], 1'b0}
                                            + {4'b0000, dval};
                  number_has_digit_next   = 1'b1;
                end else if (!has_src) begin
                  parse_failed_next = 1'b1;
                end else begin
                  pv_we = 1'b1;
                  if (phase_rel[3:1] == LAST_VALUE) begin
                    parse_phase_next = PHASE_DONE;
                  end else if (rx_byte == CHAR_COMMA) begin
                    parse_phase_next = parse_phase + 1'b1;
                  end else begin
                    parse_failed_next = 1'b1;
                  end
                end
              end
            end
          end
        end else begin
          // Overlong line: drop the byte and restart.
          line_length_next        = '0;
          parse_phase_next        = '0;
          parse_failed_next       = 1'b0;
          text_ended_next         = 1'b0;
          number_accumulator_next = 8'd0;
          number_negative_next    = 1'b0;
          number_has_digit_next   = 1'b0;
        end
      end else if (line_length != '0) begin
        res_valid               = 1'b1;
        line_length_next        = '0;
        parse_phase_next        = '0;
        parse_failed_next       = 1'b0;
        text_ended_next         = 1'b0;
        number_accumulator_next = 8'd0;
        number_negative_next    = 1'b0;
        number_has_digit_next   = 1'b0;
      end
    end
  end

  // Result fields from the state as it stands when the terminator arrives.
  always_comb begin
    ok = !parse_failed &&
         ((parse_phase == PHASE_DONE) ||
          ((parse_phase == PHASE_LAST_RUN) && number_has_digit));
    last_value = (parse_phase == PHASE_DONE) ? parsed_values[LAST_VALUE] : signed_acc;
    res = '0;
    if (ok) begin
      res.cmd_ok      = 1'b1;
      res.sec_bcd     = to_bcd(last_value);
      res.min_bcd     = to_bcd(parsed_values[4]);
      res.hour_bcd    = to_bcd(parsed_values[3]);
      res.weekday_bcd = WEEKDAY_FIXED;
      res.date_bcd    = to_bcd(parsed_values[2]);
      res.month_bcd   = to_bcd(parsed_values[1]);
      res.year_bcd    = to_bcd(parsed_values[0] - YEAR_BASE_MOD);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length        <= '0;
      parse_phase        <= '0;
      parse_failed       <= 1'b0;
      text_ended         <= 1'b0;
      number_accumulator <= 8'd0;
      number_negative    <= 1'b0;
      number_has_digit   <= 1'b0;
    end else begin
      line_length        <= line_length_next;
      parse_phase        <= parse_phase_next;
      parse_failed       <= parse_failed_next;
      text_ended         <= text_ended_next;
      number_accumulator <= number_accumulator_next;
      number_negative    <= number_negative_next;
      number_has_digit   <= number_has_digit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pv_we) begin
      parsed_values[pv_idx] <= pv_data;
    end
  end

endmodule

### sv/stclp_obuf.sv
// Result register with one skid entry behind it.
module stclp_obuf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  stclp_pkg::res_t push_data,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output stclp_pkg::res_t out_data
);
  import stclp_pkg::*;

  logic skid_valid;
  res_t skid_data;
  logic pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // Input is held off while the skid entry is occupied.
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

### sv/settime_command_line_parser_top.sv
// Time-setting command line parser: received bytes in, one result per non-empty line out.
//
// Input channel: in_valid / in_stall carry rx_byte; a byte transfers on a rising
// edge with in_valid high and in_stall low. CR or LF ends the line.
// Output channel: out_valid / out_stall carry cmd_ok and seven BCD time bytes,
// one result per non-empty line; an empty line gives nothing.
// The result is registered on the edge that transfers the terminator when the result
// register is free, else it waits in the skid entry. Throughput: one byte per cycle
// while in_stall is low; each byte updates the parse state in one pass of shallow logic.
// When the receiver stalls, the result holds and one more result fits in a skid
// entry; in_stall rises only while that entry is occupied, so bytes keep flowing
// until a second finished line is waiting.
// Lines longer than LINE_BUFFER_BYTES-1 bytes restart empty on the next byte.
// Reset (rst, synchronous, active high) clears the line and empties both result
// entries; no clearing pass follows, the block takes bytes in the next cycle.
module settime_command_line_parser_top #(
  parameter int unsigned LINE_BUFFER_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       cmd_ok,
  output logic [7:0] sec_bcd,
  output logic [7:0] min_bcd,
  output logic [7:0] hour_bcd,
  output logic [7:0] weekday_bcd,
  output logic [7:0] date_bcd,
  output logic [7:0] month_bcd,
  output logic [7:0] year_bcd
);
  import stclp_pkg::*;

  logic accept;
  logic res_valid;
  logic full;
  res_t res;
  res_t out_data;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  stclp_core #(
    .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  stclp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign cmd_ok      = out_data.cmd_ok;
  assign sec_bcd     = out_data.sec_bcd;
  assign min_bcd     = out_data.min_bcd;
  assign hour_bcd    = out_data.hour_bcd;
  assign weekday_bcd = out_data.weekday_bcd;
  assign date_bcd    = out_data.date_bcd;
  assign month_bcd   = out_data.month_bcd;
  assign year_bcd    = out_data.year_bcd;

endmodule

### sv/stclp_chk.sv
// Port-level checks for the time-setting line parser, bound to the top level.
module stclp_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic       cmd_ok,
  input logic [7:0] sec_bcd,
  input logic [7:0] min_bcd,
  input logic [7:0] hour_bcd,
  input logic [7:0] weekday_bcd,
  input logic [7:0] date_bcd,
  input logic [7:0] month_bcd,
  input logic [7:0] year_bcd
);

  // A stalled result stays valid and holds cmd_ok, sec, date and year.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cmd_ok) && $stable(sec_bcd)
      && $stable(year_bcd) && $stable(date_bcd))
    else $error("stalled result changed");

  // A rising out_valid follows only a terminator transfer.
  a_from_term: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && (rx_byte == 8'd13 || rx_byte == 8'd10)))
    else $error("result without line terminator");

  // An unknown command carries all-zero time bytes.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cmd_ok |-> sec_bcd == 8'd0 && min_bcd == 8'd0 && hour_bcd == 8'd0
      && weekday_bcd == 8'd0 && date_bcd == 8'd0 && month_bcd == 8'd0 && year_bcd == 8'd0)
    else $error("nonzero fields on unknown command");

  // A good command has weekday one and decimal low digits in sec, min and year.
  a_ok_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && cmd_ok |-> weekday_bcd == 8'd1 && sec_bcd[3:0] <= 4'd9
      && min_bcd[3:0] <= 4'd9 && year_bcd[3:0] <= 4'd9)
    else $error("malformed BCD on good command");

endmodule

bind settime_command_line_parser_top stclp_chk u_chk (.*);

### dv/tb_top.sv
// Self-checking testbench for the time-setting line parser: bytes in, results checked.
`timescale 1ns / 100ps

module tb_top;
  import stclp_pkg::*;

  localparam int unsigned LINE_BYTES   = 128;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          QUIET_LIMIT  = 4000;
  localparam int          TAIL_CYCLES  = 8;
  localparam int          TOTAL_BYTES  = 900;
  localparam int          MIN_LINES    = 6;

  localparam logic [7:0]  CH_SPACE = 8'd32;
  localparam logic [7:0]  CH_TAB   = 8'd9;
  localparam logic [7:0]  CH_VT    = 8'd11;
  localparam logic [7:0]  CH_FF    = 8'd12;
  localparam logic [7:0]  CH_ZERO  = 8'd48;
  localparam logic [7:0]  CH_NINE  = 8'd57;
  localparam logic [63:0] PREFIX   = "SETTIME,";

  typedef logic [7:0] line_q_t[$];

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       cmd_ok;
  logic [7:0] sec_bcd, min_bcd, hour_bcd, weekday_bcd, date_bcd, month_bcd, year_bcd;

  settime_command_line_parser_top #(.LINE_BUFFER_BYTES(LINE_BYTES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd_ok(cmd_ok), .sec_bcd(sec_bcd), .min_bcd(min_bcd), .hour_bcd(hour_bcd),
    .weekday_bcd(weekday_bcd), .date_bcd(date_bcd), .month_bcd(month_bcd),
    .year_bcd(year_bcd)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Line tracker state
  int unsigned line_len;
  logic [4:0]  phase;
  bit          parse_bad, text_done, acc_neg, acc_seen;
  logic [7:0]  acc;
  logic [7:0]  field_val [NUM_VALUES] = '{default: 8'h00};

  res_t expected_times[$];

  int  mismatches, results_checked, cmds_ok, bytes_sent, lines_sent, input_stalls;
  int  quiet;
  int  hold_req, hold_seen, hold_left, stall_left;
  bit  tx_idle, rx_idle;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] bcd_of(input logic [7:0] v);
    return 8'(((v / 8'd10) << 4) | (v % 8'd10));
  endfunction

  function automatic logic [7:0] run_value();
    return acc_neg ? 8'(8'd0 - acc) : acc;
  endfunction

  task automatic clear_line();
    line_len  = 0;
    phase     = '0;
    parse_bad = 1'b0;
    text_done = 1'b0;
    acc       = '0;
    acc_neg   = 1'b0;
    acc_seen  = 1'b0;
  endtask

  // Advance the line tracker by one accepted byte; queue a result at line end.
  task automatic track_rx_byte(input logic [7:0] c);
    logic [4:0] rel;
    logic [2:0] k;
    bit         digit;
    bit         ok;
    res_t       r;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (c != CHAR_CR && c != CHAR_LF) begin
      if (line_len >= LINE_BYTES - 1) begin
        // drop the byte, restart the line
        clear_line();
        return;
      end
      line_len++;
      if (text_done || parse_bad) return;
      if (c == CHAR_NUL) begin
        text_done = 1'b1;
        return;
      end
      if (phase < PHASE_FIRST_NUM) begin
        if (c == PREFIX[8 * (7 - phase) +: 8]) phase++;
        else parse_bad = 1'b1;
        return;
      end
      if (phase >= PHASE_DONE) return;
      rel = phase - PHASE_FIRST_NUM;
      k   = rel[3:1];
      if (!rel[0]) begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) return;
        if (c != CHAR_PLUS && c != CHAR_MINUS && !digit) begin
          parse_bad = 1'b1;
          return;
        end
        acc      = '0;
        acc_neg  = (c == CHAR_MINUS);
        acc_seen = 1'b0;
        phase++;
        if (!digit) return;
      end
      if (digit) begin
        acc      = 8'(acc * 8'd10 + (c - CH_ZERO));
        acc_seen = 1'b1;
        return;
      end
      if (!acc_seen) begin
        parse_bad = 1'b1;
        return;
      end
      field_val[k] = run_value();
      if (k == LAST_VALUE) phase = PHASE_DONE;
      else if (c == CHAR_COMMA) phase = PHASE_FIRST_NUM + 5'(2 * (k + 1));
      else parse_bad = 1'b1;
      return;
    end

    if (line_len == 0) return;
    ok = 1'b0;
    if (!parse_bad) begin
      if (phase == PHASE_DONE) begin
        ok = 1'b1;
      end else if (phase == PHASE_LAST_RUN && acc_seen) begin
        field_val[LAST_VALUE] = run_value();
        ok = 1'b1;
      end
    end
    r = '0;
    if (ok) begin
      r.cmd_ok      = 1'b1;
      r.sec_bcd     = bcd_of(field_val[5]);
      r.min_bcd     = bcd_of(field_val[4]);
      r.hour_bcd    = bcd_of(field_val[3]);
      r.weekday_bcd = WEEKDAY_FIXED;
      r.date_bcd    = bcd_of(field_val[2]);
      r.month_bcd   = bcd_of(field_val[1]);
      r.year_bcd    = bcd_of(field_val[0] - YEAR_BASE_MOD);
    end
    expected_times.push_back(r);
    clear_line();
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("ERROR at %0t: %s got %02h expected %02h", $realtime, what, got, want);
  endtask

  // Send one byte; hold it until the transfer, then update the tracker.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (tx_idle && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    track_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_settime(input int y, input int mo, input int d, input int h,
                              input int mi, input int s);
    send_text($sformatf("SETTIME,%0d,%0d,%0d,%0d,%0d,%0d", y, mo, d, h, mi, s));
    send_byte(CHAR_CR);
  endtask

  task automatic append_text(ref line_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endtask

  function automatic string random_command();
    string      s;
    int         r;
    int         v;
    logic [7:0] b;
    s = "SETTIME,";
    for (int i = 0; i < NUM_VALUES; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          case ($urandom_range(0, 3))
            0:       b = CH_SPACE;
            1:       b = CH_TAB;
            2:       b = CH_VT;
            default: b = CH_FF;
          endcase
          s = $sformatf("%s%c", s, b);
        end
      end
      r = $urandom_range(0, 9);
      if (r == 0) s = {s, "+"};
      else if (r == 1) s = {s, "-"};
      r = $urandom_range(0, 9);
      if (r < 6) v = (i == 0) ? $urandom_range(1990, 2150) : $urandom_range(0, 99);
      else if (r < 9) v = $urandom_range(0, 999);
      else v = $urandom_range(0, 99999999);
      if ($urandom_range(0, 9) == 0) s = {s, "0"};
      s = $sformatf("%s%0d", s, v);
      if (i < NUM_VALUES - 1) s = {s, ","};
    end
    return s;
  endfunction

  // Mostly well-formed commands, some corrupted, some noise, a few overlong lines.
  task automatic send_random_line();
    logic [7:0] q[$];
    int         kind;
    int         pos;
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      append_text(q, random_command());
      if (kind < 70) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
      end else begin
        pos = $urandom_range(0, q.size() - 1);
        case ($urandom_range(0, 4))
          0:       q[pos] = 8'($urandom_range(0, 255));
          1:       while (q.size() > pos) q.pop_back();
          2:       q.insert(pos, CHAR_NUL);
          3:       q.insert(pos, CH_SPACE);
          default: q.delete(pos);
        endcase
      end
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(120, 135)) q.push_back(8'($urandom_range(32, 126)));
      if ($urandom_range(0, 1) == 1) append_text(q, random_command());
    end
    foreach (q[i]) send_byte(q[i]);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: send_byte(CHAR_CR);
      6, 7, 8:          send_byte(CHAR_LF);
      default: begin
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
      end
    endcase
    lines_sent++;
  endtask

  // Drop valid and wait until every pending result has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_times.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic test_command_forms();
    tx_idle = 1'b1;
    rx_idle <= 1'b1;
    send_settime(2024, 5, 17, 23, 59, 58);
    send_byte(CHAR_LF);                               // empty line
    send_text("SETTIME, +2000,");
    send_byte(CH_TAB);
    send_text("-1,");
    send_byte(CH_VT);
    send_text("012,");
    send_byte(CH_FF);
    send_text("+0,  7,-0");
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_text("SETTIME,2020,-,1,1,1,1");              // sign with no digit
    send_byte(CHAR_CR);
    send_text("SETTIME,2020,+ 1,1,1,1,1");            // blank after sign
    send_byte(CHAR_CR);
    send_text("SETTIME,2021,1,1,1,1,5");              // zero byte ends the text
    send_byte(CHAR_NUL);
    send_text("9,x");
    send_byte(CHAR_CR);
    send_text("SETTIME,2021,1,1,1,1,");
    send_byte(CHAR_NUL);
    send_text("5");
    send_byte(CHAR_LF);
    send_text("SETTIME,2021,1,1,1,1");                // text ends early
    send_byte(CHAR_CR);
    send_text("SETTIME,2021,1,1,1,1,-");
    send_byte(CHAR_CR);
    send_text("SETTIME,1,2,3,4,5,6xyz");              // trailing text ignored
    send_byte(CHAR_CR);
    send_settime(999999, 255, 256, 99999, 1000, 65535);
    send_settime(-5, -1, 0, 0, 0, 0);
    send_text("settime,2024,1,1,1,1,1");
    send_byte(CHAR_CR);
    send_text("SETTIME;1");
    send_byte(CHAR_LF);
    send_text("SETTIME,2024,1,1x,1,1,1");
    send_byte(CHAR_CR);
    send_byte(CHAR_NUL);
    send_byte(8'hFF);
    send_byte(CHAR_CR);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(CHAR_LF);
    wait_for_results();
  endtask

  task automatic test_line_overflow();
    repeat (LINE_BYTES - 1) send_byte("A");
    send_byte("B");                                   // dropped, line restarts
    send_settime(2030, 12, 31, 0, 0, 1);
    repeat (LINE_BYTES - 1) send_byte("Z");
    send_byte(CHAR_CR);
    wait_for_results();
  endtask

  task automatic test_output_hold();
    tx_idle  = 1'b0;
    hold_req <= hold_req + 1;
    // keep offering lines so the result entries fill and the input stalls
    for (int i = 0; i < 4; i++) send_settime(2000 + i, i + 1, 10 + i, i, 30 + i, 59 - i);
    // pause until everything has drained, then burst again
    wait_for_results();
    for (int i = 0; i < 2; i++) send_settime(2099, 2, 29, 12, 0, i);
    wait_for_results();
  endtask

  task automatic test_random_lines();
    int first_line;
    first_line = lines_sent;
    while (bytes_sent < TOTAL_BYTES || lines_sent - first_line < MIN_LINES) begin
      if ((lines_sent % 8) == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle <= ($urandom_range(0, 3) != 0);
      end
      send_random_line();
    end
    wait_for_results();
  endtask

  // Receiver side: random stalls plus a requested long hold-off.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rx_idle && $urandom_range(0, 3) == 0) begin
      stall_left = idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {cmd_ok, sec_bcd, min_bcd, hour_bcd, weekday_bcd, date_bcd, month_bcd, year_bcd};
      if (expected_times.size() == 0) begin
        report_mismatch("result with nothing pending, cmd_ok", 8'(got.cmd_ok), 8'h00);
      end else begin
        want = expected_times.pop_front();
        results_checked++;
        if (want.cmd_ok) cmds_ok++;
        if (got.cmd_ok !== want.cmd_ok)
          report_mismatch("cmd_ok", 8'(got.cmd_ok), 8'(want.cmd_ok));
        if (got.sec_bcd !== want.sec_bcd) report_mismatch("sec_bcd", got.sec_bcd, want.sec_bcd);
        if (got.min_bcd !== want.min_bcd) report_mismatch("min_bcd", got.min_bcd, want.min_bcd);
        if (got.hour_bcd !== want.hour_bcd)
          report_mismatch("hour_bcd", got.hour_bcd, want.hour_bcd);
        if (got.weekday_bcd !== want.weekday_bcd)
          report_mismatch("weekday_bcd", got.weekday_bcd, want.weekday_bcd);
        if (got.date_bcd !== want.date_bcd)
          report_mismatch("date_bcd", got.date_bcd, want.date_bcd);
        if (got.month_bcd !== want.month_bcd)
          report_mismatch("month_bcd", got.month_bcd, want.month_bcd);
        if (got.year_bcd !== want.year_bcd)
          report_mismatch("year_bcd", got.year_bcd, want.year_bcd);
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (in_valid && in_stall) input_stalls++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Watchdog: %0d cycles without a transfer, %0d results pending",
                 quiet, expected_times.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    clear_line();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_command_forms();
    test_line_overflow();
    test_output_hold();
    test_random_lines();
    if (expected_times.size() != 0)
      report_mismatch("results never delivered, count", 8'(expected_times.size()), 8'h00);
    $display("Checked %0d results (%0d valid commands) from %0d bytes; input stalled %0d cycles.",
             results_checked, cmds_ok, bytes_sent, input_stalls);
    $display("Covered blanks, signs, zero bytes, overlong lines, a %0d-cycle output hold, idling.",
             HOLD_CYCLES);
    if (mismatches == 0 && expected_times.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
